/* design/derp_pkg.sv */
// ----------------------------------------------------------------------------
// derp_pkg: shared types and constants of the reply parser
// Parse phases, configuration bundle, result item layout and number limits.
// ----------------------------------------------------------------------------
package derp_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_ERRTEXT = 3'd2,
        PH_COUNT   = 3'd3,
        PH_ROWS    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        CFG_DELIM  = 3'd0,
        CFG_EOL    = 3'd1,
        CFG_ESC    = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_NULL   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_FIELD   = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OC_FAILED  = 2'd0,
        OC_SUCCESS = 2'd1,
        OC_COUNT   = 2'd2,
        OC_ROWS    = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [7:0] delim_code;
        logic [7:0] eol_code;
        logic [7:0] esc_code;
        logic [7:0] esc_offset;
        logic [7:0] null_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         data_byte;
        logic               is_error_text;
        logic               field_is_null;
        logic               row_end;
        logic               reply_done;
        logic [1:0]         outcome;
        logic signed [31:0] error_code;
        logic [15:0]        column_count;
        logic [31:0]        affected_count;
    } t_result;

    localparam int unsigned ACC_W = 33;
    // The magnitude saturates at 2^32.
    localparam logic [ACC_W-1:0] NUM_CAP = 33'h1_0000_0000;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

endpackage

/* design/delimited_escaped_response_parser_top.sv */
// ----------------------------------------------------------------------------
// delimited_escaped_response_parser_top: byte-serial reply line parser
// Parses header tokens, unescapes error text and fields, and reports field
// ends and reply summaries.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid / tready         tdata: in_byte, tuser: count_mode
//   m_axis    out        tvalid / tready         tdata: result fields, tuser: kind,
//                                                tlast: reply_done
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while the output is not stalled; each item
// passes through the input register, then the parse step into the result
// register. The parse state loop is a single compare and decimal accumulate
// step, so items run back to back. A stall on the output holds both
// registers; the input side still takes an item while the input register is
// empty. Reset is synchronous and returns the parser to the first header
// token with the default codes.
// ----------------------------------------------------------------------------
module delimited_escaped_response_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] count_mode
    // Result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // [7:0] data_byte, [8] is_error_text,
                                          // [9] field_is_null, [10] row_end,
                                          // [12:11] outcome, [44:13] error_code,
                                          // [60:45] column_count,
                                          // [92:61] affected_count, [95:93] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,   // reply_done
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    derp_pkg::t_cfg    cfg;
    derp_pkg::t_result core_res;
    derp_pkg::t_result r_out;
    logic              core_vld;
    logic              advance;
    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_cm;
    logic              r_out_vld;

    // The whole pipe moves when the result register is free or being drained.
    assign advance         = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || advance;

    derp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    derp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_vld && advance),
        .i_byte       (r_in_byte),
        .i_count_mode (r_in_cm),
        .i_cfg        (cfg),
        .o_res_vld    (core_vld),
        .o_res        (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_cm   <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= core_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_vld) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.reply_done;
    assign o_m_axis_tdata  = {3'b000,
                              r_out.affected_count,
                              r_out.column_count,
                              r_out.error_code,
                              r_out.outcome,
                              r_out.row_end,
                              r_out.field_is_null,
                              r_out.is_error_text,
                              r_out.data_byte};

endmodule

/* design/derp_cfg.sv */
// ----------------------------------------------------------------------------
// derp_cfg: configuration registers
// Holds the delimiter, end-of-line, escape and null marker codes and the escape offset.
// ----------------------------------------------------------------------------
module derp_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [2:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output logic            o_cfg_ready,
    output derp_pkg::t_cfg  o_cfg
);

    derp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim_code <= 8'd9;
            r_cfg.eol_code   <= 8'd10;
            r_cfg.esc_code   <= 8'd1;
            r_cfg.esc_offset <= 8'd64;
            r_cfg.null_code  <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                derp_pkg::CFG_DELIM:  r_cfg.delim_code <= i_cfg_data;
                derp_pkg::CFG_EOL:    r_cfg.eol_code   <= i_cfg_data;
                derp_pkg::CFG_ESC:    r_cfg.esc_code   <= i_cfg_data;
                derp_pkg::CFG_OFFSET: r_cfg.esc_offset <= i_cfg_data;
                derp_pkg::CFG_NULL:   r_cfg.null_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* design/derp_core.sv */
// ----------------------------------------------------------------------------
// derp_core: reply parse state and one-byte step logic
// Updates the parse state for one byte and forms the result item, if any.
// ----------------------------------------------------------------------------
module derp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic              i_count_mode,
    input  derp_pkg::t_cfg    i_cfg,
    output logic              o_res_vld,
    output derp_pkg::t_result o_res
);

    localparam int unsigned AW = derp_pkg::ACC_W;

    derp_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0]    r_acc, n_acc;
    logic             r_neg, n_neg;
    logic             r_stop, n_stop;
    logic             r_begun, n_begun;
    logic [31:0]      r_err, n_err;
    logic [15:0]      r_col, n_col;
    logic [15:0]      r_fir, n_fir;
    logic             r_esc_pend, n_esc_pend;
    logic             r_null_seen, n_null_seen;
    logic             r_nonempty, n_nonempty;
    logic             r_cm, n_cm;
    logic             r_start, n_start;

    logic        eol, delim, is_esc, is_null;
    logic [7:0]  esc_byte, fb;
    logic        cm_eff;

    // Number step
    logic        ws, sign, digit;
    logic [AW+3:0] v;
    logic [AW-1:0] nf_acc;
    logic        nf_neg, nf_stop, nf_begun;

    // Conversions of the current accumulator
    logic [31:0] s32, u32;
    logic [15:0] c16;

    // Step control
    logic        ch_do, ch_eol, feed, num_clr, do_reset;
    logic [31:0] ch_err;
    logic [15:0] ch_col;
    logic [15:0] fir_inc;
    logic        rowend;

    assign eol      = (i_byte == i_cfg.eol_code);
    assign delim    = (i_byte == i_cfg.delim_code);
    assign is_esc   = (i_byte == i_cfg.esc_code);
    assign is_null  = (i_byte == i_cfg.null_code);
    assign esc_byte = i_byte - i_cfg.esc_offset;
    assign fb       = (r_phase == derp_pkg::PH_COUNT && r_esc_pend) ? esc_byte : i_byte;
    assign cm_eff   = r_start ? i_count_mode : r_cm;
    assign fir_inc  = r_fir + 16'd1;
    assign rowend   = (fir_inc == r_col);

    assign ws    = (fb == derp_pkg::CH_SPACE) || (fb >= derp_pkg::CH_HT && fb <= derp_pkg::CH_CR);
    assign sign  = (fb == derp_pkg::CH_PLUS) || (fb == derp_pkg::CH_MINUS);
    assign digit = (fb >= derp_pkg::CH_ZERO) && (fb <= derp_pkg::CH_NINE);
    // acc * 10 + digit as two shifted adds
    assign v = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {{(AW){1'b0}}, fb[3:0]};

    always_comb begin
        nf_acc   = r_acc;
        nf_neg   = r_neg;
        nf_stop  = r_stop;
        nf_begun = r_begun;
        if (!r_stop) begin
            if (!r_begun && ws) begin
                nf_begun = 1'b0;
            end else if (!r_begun && sign) begin
                nf_begun = 1'b1;
                nf_neg   = (fb == derp_pkg::CH_MINUS);
            end else begin
                nf_begun = 1'b1;
                if (digit) begin
                    nf_acc = (v > {4'b0000, derp_pkg::NUM_CAP}) ? derp_pkg::NUM_CAP
                                                                  : v[AW-1:0];
                end else begin
                    nf_stop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            s32 = (r_acc >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - r_acc[31:0]);
            c16 = 16'd0;
            u32 = 32'd0;
        end else begin
            s32 = (r_acc > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_acc[31:0];
            c16 = (r_acc > 33'h0_0000_FFFF) ? 16'hFFFF : r_acc[15:0];
            u32 = r_acc[32] ? 32'hFFFF_FFFF : r_acc[31:0];
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_stop      = r_stop;
        n_begun     = r_begun;
        n_err       = r_err;
        n_col       = r_col;
        n_fir       = r_fir;
        n_esc_pend  = r_esc_pend;
        n_null_seen = r_null_seen;
        n_nonempty  = r_nonempty;
        n_cm        = r_cm;
        n_start     = r_start;
        o_res_vld   = 1'b0;
        o_res       = '0;
        ch_do       = 1'b0;
        ch_eol      = 1'b0;
        ch_err      = r_err;
        ch_col      = r_col;
        feed        = 1'b0;
        num_clr     = 1'b0;
        do_reset    = 1'b0;

        if (i_en) begin
            n_cm    = cm_eff;
            n_start = 1'b0;

            case (r_phase)
                derp_pkg::PH_HDR0: begin
                    if (eol || delim) begin
                        n_err   = s32;
                        num_clr = 1'b1;
                        if (eol) begin
                            n_col  = 16'd0;
                            ch_do  = 1'b1;
                            ch_eol = 1'b1;
                            ch_err = s32;
                            ch_col = 16'd0;
                        end else begin
                            n_phase = derp_pkg::PH_HDR1;
                        end
                    end else begin
                        feed = 1'b1;
                    end
                end
                derp_pkg::PH_HDR1: begin
                    if (eol || delim) begin
                        n_col  = c16;
                        ch_do  = 1'b1;
                        ch_eol = eol;
                        ch_col = c16;
                    end else begin
                        feed = 1'b1;
                    end
                end
                derp_pkg::PH_ERRTEXT: begin
                    if (eol) begin
                        o_res_vld          = 1'b1;
                        o_res.kind         = derp_pkg::KIND_SUMMARY;
                        o_res.reply_done   = 1'b1;
                        o_res.outcome      = derp_pkg::OC_FAILED;
                        o_res.error_code   = r_err;
                        o_res.column_count = r_col;
                        do_reset           = 1'b1;
                    end else if (is_esc) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        n_esc_pend          = 1'b0;
                        o_res_vld           = 1'b1;
                        o_res.kind          = derp_pkg::KIND_DATA;
                        o_res.data_byte     = r_esc_pend ? esc_byte : i_byte;
                        o_res.is_error_text = 1'b1;
                    end
                end
                derp_pkg::PH_COUNT: begin
                    if (eol) begin
                        o_res_vld            = 1'b1;
                        o_res.kind           = derp_pkg::KIND_SUMMARY;
                        o_res.reply_done     = 1'b1;
                        o_res.outcome        = derp_pkg::OC_COUNT;
                        o_res.column_count   = r_col;
                        o_res.affected_count = u32;
                        do_reset             = 1'b1;
                    end else if (is_esc) begin
                        n_esc_pend = 1'b1;
                    end else begin
                        n_esc_pend = 1'b0;
                        feed       = 1'b1;
                    end
                end
                derp_pkg::PH_ROWS: begin
                    if (eol || delim) begin
                        o_res_vld           = 1'b1;
                        o_res.kind          = derp_pkg::KIND_FIELD;
                        o_res.field_is_null = !r_nonempty && r_null_seen;
                        o_res.row_end       = rowend;
                        n_fir               = rowend ? 16'd0 : fir_inc;
                        n_null_seen         = 1'b0;
                        n_nonempty          = 1'b0;
                        if (eol) begin
                            o_res.reply_done   = 1'b1;
                            o_res.outcome      = derp_pkg::OC_ROWS;
                            o_res.column_count = r_col;
                            do_reset           = 1'b1;
                        end
                    end else if (is_esc) begin
                        n_esc_pend = 1'b1;
                    end else if (r_esc_pend) begin
                        n_esc_pend      = 1'b0;
                        n_nonempty      = 1'b1;
                        o_res_vld       = 1'b1;
                        o_res.kind      = derp_pkg::KIND_DATA;
                        o_res.data_byte = esc_byte;
                    end else if (is_null) begin
                        n_null_seen = 1'b1;
                    end else begin
                        n_nonempty      = 1'b1;
                        o_res_vld       = 1'b1;
                        o_res.kind      = derp_pkg::KIND_DATA;
                        o_res.data_byte = i_byte;
                    end
                end
                default: begin
                    do_reset = 1'b1;
                end
            endcase

            if (feed) begin
                n_acc   = nf_acc;
                n_neg   = nf_neg;
                n_stop  = nf_stop;
                n_begun = nf_begun;
            end

            // Header close: an error header switches to error text, a clean
            // header picks the body mode, and end of line gives a summary.
            if (ch_do) begin
                num_clr = 1'b1;
                if (ch_eol) begin
                    o_res_vld          = 1'b1;
                    o_res.kind         = derp_pkg::KIND_SUMMARY;
                    o_res.reply_done   = 1'b1;
                    o_res.error_code   = ch_err;
                    o_res.column_count = ch_col;
                    do_reset           = 1'b1;
                    if (ch_err != 32'd0) begin
                        o_res.outcome = derp_pkg::OC_FAILED;
                    end else if (ch_col == 16'd1) begin
                        o_res.outcome = derp_pkg::OC_SUCCESS;
                    end else if (cm_eff) begin
                        o_res.outcome = derp_pkg::OC_COUNT;
                    end else begin
                        o_res.outcome = derp_pkg::OC_ROWS;
                    end
                end else if (ch_err != 32'd0) begin
                    n_phase = derp_pkg::PH_ERRTEXT;
                end else begin
                    n_phase = cm_eff ? derp_pkg::PH_COUNT : derp_pkg::PH_ROWS;
                end
            end

            if (num_clr) begin
                n_acc   = '0;
                n_neg   = 1'b0;
                n_stop  = 1'b0;
                n_begun = 1'b0;
            end

            if (do_reset) begin
                n_phase     = derp_pkg::PH_HDR0;
                n_acc       = '0;
                n_neg       = 1'b0;
                n_stop      = 1'b0;
                n_begun     = 1'b0;
                n_err       = 32'd0;
                n_col       = 16'd0;
                n_fir       = 16'd0;
                n_esc_pend  = 1'b0;
                n_null_seen = 1'b0;
                n_nonempty  = 1'b0;
                n_start     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= derp_pkg::PH_HDR0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_stop      <= 1'b0;
            r_begun     <= 1'b0;
            r_err       <= 32'd0;
            r_col       <= 16'd0;
            r_fir       <= 16'd0;
            r_esc_pend  <= 1'b0;
            r_null_seen <= 1'b0;
            r_nonempty  <= 1'b0;
            r_cm        <= 1'b0;
            r_start     <= 1'b1;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_stop      <= n_stop;
            r_begun     <= n_begun;
            r_err       <= n_err;
            r_col       <= n_col;
            r_fir       <= n_fir;
            r_esc_pend  <= n_esc_pend;
            r_null_seen <= n_null_seen;
            r_nonempty  <= n_nonempty;
            r_cm        <= n_cm;
            r_start     <= n_start;
        end
    end

endmodule
